[hw/rtl/cfws_pkg.sv]
// Shared types and codes for the circular FIFO with search.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package cfws_pkg;

  typedef enum logic [1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_STATUS = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_SRCH   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic rdwait;
    logic srch;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go_read;
    logic go_srch;
    logic srch_end;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/cfws_req_if.sv]
// Request channel: valid/ready handshake carrying action and value.
// No dependencies.
`default_nettype none

interface cfws_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

[hw/rtl/cfws_rsp_if.sv]
// Response channel: valid/ready handshake carrying status and queue state.
// No dependencies.
`default_nettype none

interface cfws_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               found;
  logic [6:0]         position;
  logic signed [31:0] front_value;
  logic signed [31:0] rear_value;
  logic [7:0]         count;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, output status, output found, output position,
                  output front_value, output rear_value, output count,
                  output is_empty, output is_full, input ready);
  modport sink (input valid, input status, input found, input position,
                input front_value, input rear_value, input count,
                input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

[hw/rtl/cfws_ctrl.sv]
// Controller state machine: sequences one request through execute, read and search.
// Depends on cfws_pkg.
`default_nettype none

module cfws_ctrl
  import cfws_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.go_read) begin
          state_d = S_RDWAIT;
        end else if (sts_i.go_srch) begin
          state_d = S_SRCH;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RDWAIT: begin
        cmd_o.rdwait = 1'b1;
        state_d      = S_DONE;
      end
      S_SRCH: begin
        cmd_o.srch = 1'b1;
        if (sts_i.srch_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/cfws_dp.sv]
// Datapath: slot memory, head/tail/count, front/rear copies, search scan, result register.
// Depends on cfws_pkg.
`default_nettype none

module cfws_dp
  import cfws_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [31:0] value_i,
  output logic [1:0]              status_o,
  output logic                    found_o,
  output logic [6:0]              position_o,
  output logic signed [31:0]      front_value_o,
  output logic signed [31:0]      rear_value_o,
  output logic [7:0]              count_o,
  output logic                    is_empty_o,
  output logic                    is_full_o
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);
  localparam logic [CntW-1:0] OneCnt  = CntW'(1);

  function automatic logic [IdxW-1:0] wrap_next(input logic [IdxW-1:0] idx);
    wrap_next = (idx == LastIdx) ? '0 : idx + IdxW'(1);
  endfunction

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rd_data_q;
  logic [IdxW-1:0]    rd_addr;

  action_e            act_q;
  logic signed [31:0] val_q;
  logic [IdxW-1:0]    head_q, tail_q, scan_q;
  logic [CntW-1:0]    held_q, left_q;
  logic signed [31:0] front_q, rear_q;
  status_e            res_status_q;
  logic               res_found_q;
  logic [IdxW-1:0]    res_pos_q;

  logic               is_empty, is_full, enq_ok, deq_ok, match;
  logic [IdxW-1:0]    tail_nx, head_nx;
  logic [CntW+7:0]    cnt_ext;
  logic [IdxW+6:0]    pos_ext;

  assign is_empty = (held_q == '0);
  assign is_full  = (held_q == FullCnt);
  assign tail_nx  = wrap_next(tail_q);
  assign head_nx  = wrap_next(head_q);
  assign enq_ok   = cmd_i.exec && (act_q == ACT_ENQ) && !is_full;
  assign deq_ok   = cmd_i.exec && (act_q == ACT_DEQ) && !is_empty;
  assign match    = (rd_data_q == val_q);

  assign sts_o.go_read  = (act_q == ACT_DEQ) && (held_q > OneCnt);
  assign sts_o.go_srch  = (act_q == ACT_SEARCH) && !is_empty;
  assign sts_o.srch_end = match || (left_q == OneCnt);

  // one read a beat: new front after a dequeue, the next slot of the scan, else the head slot
  always_comb begin
    rd_addr = head_q;
    if (cmd_i.exec && (act_q == ACT_DEQ)) begin
      rd_addr = head_nx;
    end else if (cmd_i.srch) begin
      rd_addr = wrap_next(scan_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq_ok) begin
      mem[tail_nx] <= val_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= LastIdx;
      held_q <= '0;
    end else begin
      if (enq_ok) begin
        tail_q <= tail_nx;
        held_q <= held_q + OneCnt;
      end else if (deq_ok) begin
        head_q <= head_nx;
        held_q <= held_q - OneCnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q <= action_e'(action_i);
      val_q <= value_i;
    end
    if (cmd_i.exec) begin
      res_status_q <= ST_OK;
      res_found_q  <= 1'b0;
      res_pos_q    <= '0;
      scan_q       <= head_q;
      left_q       <= held_q;
      case (act_q)
        ACT_ENQ: begin
          if (is_full) begin
            res_status_q <= ST_FULL;
          end else begin
            rear_q <= val_q;
            if (is_empty) begin
              front_q <= val_q;
            end
          end
        end
        ACT_DEQ: begin
          if (is_empty) begin
            res_status_q <= ST_EMPTY;
          end
        end
        ACT_SEARCH: res_status_q <= ST_NOT_FOUND;
        ACT_STATUS: res_status_q <= ST_OK;
        default:    res_status_q <= ST_OK;
      endcase
    end
    if (cmd_i.rdwait) begin
      front_q <= rd_data_q;
    end
    if (cmd_i.srch) begin
      scan_q <= wrap_next(scan_q);
      left_q <= left_q - OneCnt;
      if (match) begin
        res_status_q <= ST_OK;
        res_found_q  <= 1'b1;
        res_pos_q    <= scan_q;
      end
    end
  end

  assign cnt_ext = {8'd0, held_q};
  assign pos_ext = {7'd0, res_pos_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o      <= res_status_q;
      found_o       <= res_found_q;
      position_o    <= pos_ext[6:0];
      front_value_o <= is_empty ? 32'sd0 : front_q;
      rear_value_o  <= is_empty ? 32'sd0 : rear_q;
      count_o       <= cnt_ext[7:0];
      is_empty_o    <= is_empty;
      is_full_o     <= is_full;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/circular_fifo_with_search_core.sv]
// Circular FIFO of signed 32-bit words with front-to-rear key search.
// Enqueue, failed dequeue and status read go from execute straight to the result hand-over.
// Dequeue that leaves words behind adds one slot-memory read for the new front.
// Search: one slot compared per cycle on the single read port, until a match or the rear.
// One request in flight; the next is taken while the result waits in the output register.
// Async active-low reset empties the queue.
`default_nettype none

module circular_fifo_with_search_core
  import cfws_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cfws_req_if.sink    req_i,
  cfws_rsp_if.source  rsp_o
);

  cmd_t cmd;
  sts_t sts;

  cfws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cfws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (req_i.action),
    .value_i       (req_i.value),
    .status_o      (rsp_o.status),
    .found_o       (rsp_o.found),
    .position_o    (rsp_o.position),
    .front_value_o (rsp_o.front_value),
    .rear_value_o  (rsp_o.rear_value),
    .count_o       (rsp_o.count),
    .is_empty_o    (rsp_o.is_empty),
    .is_full_o     (rsp_o.is_full)
  );

endmodule

`default_nettype wire

[verif/cfws_checker.sv]
// Response checker for the circular FIFO with search: watches both channels,
// keeps its own ring-buffer copy and compares every response beat.
// Depends on cfws_pkg, cfws_req_if and cfws_rsp_if.

module cfws_checker
  import cfws_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cfws_req_if       req_i,
  cfws_rsp_if       rsp_i,
  output int        mismatch_cnt_o,
  output int        outstanding_o
);

  localparam int PosW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  typedef struct {
    status_e            status;
    logic               found;
    logic [PosW-1:0]    position;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic [CntW-1:0]    count;
    logic               is_empty;
    logic               is_full;
  } queue_view_t;

  logic signed [31:0] ring [DEPTH];
  int unsigned        head_idx;
  int unsigned        tail_idx;
  int unsigned        held;
  queue_view_t        awaited_q[$];
  int                 rsp_beats;

  // Apply one request to the local ring and return the view it should produce.
  function automatic queue_view_t apply_request(action_e act, logic signed [31:0] word);
    queue_view_t v;
    int unsigned idx;
    int unsigned k;
    v.status      = ST_OK;
    v.found       = 1'b0;
    v.position    = '0;
    v.front_value = '0;
    v.rear_value  = '0;
    case (act)
      ACT_ENQ: begin
        if (held == DEPTH) begin
          v.status = ST_FULL;
        end else begin
          tail_idx       = (tail_idx + 1) % DEPTH;
          ring[tail_idx] = word;
          held++;
        end
      end
      ACT_DEQ: begin
        if (held == 0) begin
          v.status = ST_EMPTY;
        end else begin
          head_idx = (head_idx + 1) % DEPTH;
          held--;
        end
      end
      ACT_SEARCH: begin
        v.status = ST_NOT_FOUND;
        idx = head_idx;
        for (k = 0; k < held && !v.found; k++) begin
          if (ring[idx] == word) begin
            v.status   = ST_OK;
            v.found    = 1'b1;
            v.position = idx[PosW-1:0];
          end else begin
            idx = (idx + 1) % DEPTH;
          end
        end
      end
      default: ;
    endcase
    if (held != 0) begin
      v.front_value = ring[head_idx];
      v.rear_value  = ring[tail_idx];
    end
    v.count    = held[CntW-1:0];
    v.is_empty = (held == 0);
    v.is_full  = (held == DEPTH);
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] response beat %0d: %s got 0x%08h, expected 0x%08h",
             $time, rsp_beats, what, got, want);
    mismatch_cnt_o++;
  endtask

  task automatic compare_beat(queue_view_t want);
    if (rsp_i.status !== want.status)
      report_mismatch("status", rsp_i.status, want.status);
    if (rsp_i.found !== want.found)
      report_mismatch("found", rsp_i.found, want.found);
    if (rsp_i.position !== want.position)
      report_mismatch("position", rsp_i.position, want.position);
    if (rsp_i.front_value !== want.front_value)
      report_mismatch("front_value", rsp_i.front_value, want.front_value);
    if (rsp_i.rear_value !== want.rear_value)
      report_mismatch("rear_value", rsp_i.rear_value, want.rear_value);
    if (rsp_i.count !== want.count)
      report_mismatch("count", rsp_i.count, want.count);
    if (rsp_i.is_empty !== want.is_empty)
      report_mismatch("is_empty", rsp_i.is_empty, want.is_empty);
    if (rsp_i.is_full !== want.is_full)
      report_mismatch("is_full", rsp_i.is_full, want.is_full);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx = 0;
      tail_idx = DEPTH - 1;
      held     = 0;
      awaited_q.delete();
    end else begin
      // Check before predicting: a beat accepted now cannot answer a request taken now.
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("unexpected beat, status", rsp_i.status, '0);
        end else begin
          compare_beat(awaited_q.pop_front());
        end
        rsp_beats++;
      end
      if (req_i.valid && req_i.ready) begin
        awaited_q.push_back(apply_request(action_e'(req_i.action), req_i.value));
      end
    end
    outstanding_o = awaited_q.size();
  end

endmodule

[verif/tb_top.sv]
// Testbench top for circular_fifo_with_search_core: clock, reset, request and
// ready stimulus, watchdog and verdict. Checking lives in cfws_checker.
// Depends on cfws_pkg, both channel interfaces, the core and cfws_checker.

module tb_top;
  import cfws_pkg::*;

  localparam int DEPTH       = 128;
  localparam int ITEM_TARGET = 1650;
  localparam int STALL_LIMIT = 3000;
  localparam int POOL_MAX    = 96;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cfws_req_if req_if ();
  cfws_rsp_if rsp_if ();

  int mismatch_cnt;
  int outstanding;
  int send_idle_pct;
  int recv_idle_pct;
  int sent;
  int fill_level;
  int quiet_cycles;
  logic signed [31:0] key_pool[$];

  circular_fifo_with_search_core #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  cfws_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .mismatch_cnt_o(mismatch_cnt),
    .outstanding_o (outstanding)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Abort when neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $urandom_range(1) ? 32'sd0 : -32'sd1;
      3, 4:    return $signed($urandom_range(15)) - 32'sd8;
      default: return $signed($urandom);
    endcase
  endfunction

  // Mostly search for words that were recently enqueued so hits are common.
  function automatic logic signed [31:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(9) < 6)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    return pick_word();
  endfunction

  // Call at a rising edge; returns at the edge where the beat was taken.
  task automatic send_item(action_e act, logic signed [31:0] word);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.value  <= word;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = req_if.ready;
      @(posedge clk_i);
    end
    sent++;
    if (act == ACT_ENQ && fill_level < DEPTH) begin
      fill_level++;
      key_pool.push_back(word);
      if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
    end else if (act == ACT_DEQ && fill_level > 0) begin
      fill_level--;
    end
  endtask

  // Hold the request side quiet until every response is back; returns at a falling edge.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  task automatic run_burst(bit force_fill);
    int mode;
    int r;
    mode = force_fill ? 0 : $urandom_range(9);
    if (mode < 2) begin
      while (fill_level < DEPTH) begin
        if ($urandom_range(9) == 0) send_item(ACT_SEARCH, pick_key());
        else send_item(ACT_ENQ, pick_word());
      end
      repeat ($urandom_range(1, 3)) send_item(ACT_ENQ, pick_word());
      send_item(ACT_SEARCH, pick_key());
    end else if (mode < 4) begin
      while (fill_level > 0) begin
        r = $urandom_range(9);
        if (r == 0) send_item(ACT_SEARCH, pick_key());
        else if (r == 1) send_item(ACT_STATUS, $signed($urandom));
        else send_item(ACT_DEQ, $signed($urandom));
      end
      repeat ($urandom_range(1, 3)) send_item(ACT_DEQ, $signed($urandom));
      send_item(ACT_SEARCH, pick_key());
    end else begin
      repeat ($urandom_range(20, 80)) begin
        r = $urandom_range(99);
        if (r < 35) send_item(ACT_ENQ, pick_word());
        else if (r < 65) send_item(ACT_DEQ, $signed($urandom));
        else if (r < 88) send_item(ACT_SEARCH, pick_key());
        else send_item(ACT_STATUS, $signed($urandom));
      end
    end
  endtask

  initial begin
    int phase;
    bit first_burst;
    req_if.valid  <= 1'b0;
    req_if.action <= ACT_STATUS;
    req_if.value  <= '0;
    send_idle_pct = 32;
    recv_idle_pct = 48;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue: status, refused dequeue, search with nothing held.
    send_item(ACT_STATUS, 32'sd0);
    send_item(ACT_DEQ, -32'sd1);
    send_item(ACT_SEARCH, 32'sd0);
    // Extremes, with a duplicate so the first match must win.
    send_item(ACT_ENQ, 32'sh7FFF_FFFF);
    send_item(ACT_ENQ, 32'sh8000_0000);
    send_item(ACT_ENQ, 32'sd0);
    send_item(ACT_ENQ, -32'sd1);
    send_item(ACT_ENQ, 32'sh7FFF_FFFF);
    send_item(ACT_SEARCH, 32'sh7FFF_FFFF);
    send_item(ACT_SEARCH, -32'sd1);
    send_item(ACT_SEARCH, 32'sh8000_0000);
    send_item(ACT_SEARCH, 32'sd12345);
    send_item(ACT_STATUS, 32'sh5555_AAAA);
    send_item(ACT_DEQ, 32'shAAAA_5555);
    send_item(ACT_SEARCH, 32'sh7FFF_FFFF);
    repeat (4) send_item(ACT_DEQ, $signed($urandom));
    send_item(ACT_DEQ, $signed($urandom));
    send_item(ACT_STATUS, $signed($urandom));

    wait_drained();
    @(posedge clk_i);

    phase = 0;
    first_burst = 1'b1;
    while (sent < ITEM_TARGET) begin
      if (phase == 0 && sent >= ITEM_TARGET / 3) begin
        wait_drained();
        send_idle_pct = 48;
        recv_idle_pct = 32;
        phase = 1;
        @(posedge clk_i);
      end else if (phase == 1 && sent >= 2 * ITEM_TARGET / 3) begin
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase = 2;
        @(posedge clk_i);
      end
      run_burst(first_burst);
      first_burst = 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
